FILE: sv/adf_pkg.sv
package adf_pkg;

    localparam int RegCount   = 6;
    localparam int QueueDepth = 2;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TIME  = 2'd2;

    localparam logic [2:0] R_ADDR = 3'd0;
    localparam logic [2:0] R_LEN  = 3'd1;
    localparam logic [2:0] R_CTRL = 3'd2;
    localparam logic [2:0] R_STAT = 3'd3;
    localparam logic [2:0] R_DAC  = 3'd4;
    localparam logic [2:0] R_BITS = 3'd5;

    localparam logic [1:0] CFG_VCLK = 2'd0;
    localparam logic [1:0] CFG_CPS  = 2'd1;
    localparam logic [1:0] CFG_FIX  = 2'd2;

    localparam logic [31:0] VCLK_RESET = 32'd48681812;
    localparam logic [31:0] CPS_RESET  = 32'd46875000;
    localparam logic [31:0] RATE_DEFAULT = 32'd44100;
    localparam logic [31:0] BITS_DEFAULT = 32'd16;

    localparam int InW  = 2 + 3 + 32 + 32 + 16;
    localparam int InTW = 88;
    localparam int OutW = 32 * 5 + 4;
    localparam int OutTW = 168;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RATE_DIV,
        ST_DUR_MUL,
        ST_DUR_DIV,
        ST_REM_MUL,
        ST_REM_DIV,
        ST_FMT_DIV,
        ST_BEGIN,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture input item, clear result
        logic rate_start;  // divider: video clock / (1 + dac)
        logic mul_dur;     // product len * cps
        logic dur_start;   // divider: product / (4 * rate)
        logic rem_mul;     // product counts_left * qlen0
        logic rem_start;   // divider: product / qdur0
        logic exec;        // simple item effects (read, writes, time)
        logic len_queue;   // queue the length write
        logic begin_xfer;  // begin transfer from entry 0
        logic rem_done;    // write remaining length to result
        logic out_valid;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] idx;
        logic       busy;
        logic       full;
        logic       time_end;  // time item ends the active transfer
        logic       rem_ok;    // remaining length needs a division
        logic       dirty;
        logic       div_done;
        logic       out_taken;
    } stat_t;

endpackage

FILE: sv/audio_dma_fifo_controller.sv
// channel  dir  tdata fields (low bit up)
// s_       in   op, reg_index, write_data, write_mask, elapsed_counts
// m_       out  read_data, dma_start, dma_address, transfer length, format_update,
//               sample_rate, sample_bits, irq_raise, irq_clear
// cfg_     in   index 0 video_clock_hz, 1 cpu_counts_per_sec, 2 fixed_dram_position
// one word at a time; a read of a register or any simple item uses no divider pass
// a length write makes two passes of the 64-step shared divider (rate, then duration);
// a length read while busy with counts left and a nonzero duration, and a time item that
// starts a queued transfer with a new format, make one pass
// synchronous active-low reset; a stalled result holds until m_tready
module audio_dma_fifo_controller (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // op, reg_index, write_data, write_mask, elapsed_counts
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // read_data, dma_start, dma_address, transfer length,
                                    // format_update, sample_rate, sample_bits, irq_raise,
                                    // irq_clear
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import adf_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic [OutW-1:0] out_item;

    adf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .st(st), .cmd(cmd)
    );

    adf_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_tdata[InW-1:0]), .m_ready(m_tready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .st(st), .out_item(out_item)
    );

    assign m_tvalid = cmd.out_valid;
    assign m_tdata = {{(OutTW - OutW){1'b0}}, out_item};

endmodule

FILE: sv/adf_div.sv
module adf_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [63:0] quo,
    output logic        done
);
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // restoring division, one quotient bit a cycle
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        trial = {r_reg[63:0], q_reg[63]} - {1'b0, d_reg};
        if (start) begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = 7'd64;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (!trial[64]) begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = {r_reg[63:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        if (!aresetn) begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    // quotient is complete in the cycle after the last step
    assign quo  = q_reg;
    assign done = done_reg;

endmodule

FILE: sv/adf_ctrl.sv
module adf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  adf_pkg::stat_t st,
    output adf_pkg::cmd_t  cmd
);
    import adf_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (st.op == OP_WRITE && st.idx == R_LEN) state_next = ST_RATE_DIV;
                else if (st.op == OP_READ && st.idx == R_LEN && st.rem_ok)
                    state_next = ST_REM_MUL;
                else if (st.op == OP_TIME && st.time_end && st.full)
                    state_next = st.dirty ? ST_FMT_DIV : ST_BEGIN;
                else state_next = ST_OUT;
            end
            ST_RATE_DIV: begin
                if (st.div_done) state_next = ST_DUR_MUL;
            end
            ST_DUR_MUL: state_next = ST_DUR_DIV;
            // busy is still the value from before the queue write
            ST_DUR_DIV: begin
                if (st.div_done) state_next = st.busy ? ST_OUT : ST_BEGIN;
            end
            ST_REM_MUL: state_next = ST_REM_DIV;
            ST_REM_DIV: begin
                if (st.div_done) state_next = ST_OUT;
            end
            ST_FMT_DIV: begin
                if (st.div_done) state_next = ST_BEGIN;
            end
            ST_BEGIN: state_next = ST_OUT;
            ST_OUT: begin
                if (st.out_taken) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE: begin
                if (st.op == OP_WRITE && st.idx == R_LEN) cmd.rate_start = 1'b1;
                else if (st.op == OP_READ && st.idx == R_LEN && st.rem_ok)
                    cmd.rem_mul = 1'b1;
                else begin
                    cmd.exec = 1'b1;
                    if (st.op == OP_TIME && st.time_end && st.full && st.dirty)
                        cmd.rate_start = 1'b1;
                end
            end
            ST_DUR_MUL: cmd.mul_dur = 1'b1;
            ST_RATE_DIV: begin
                if (st.div_done) cmd.mul_dur = 1'b1;
            end
            ST_DUR_DIV: begin
                if (st.div_done) cmd.len_queue = 1'b1;
            end
            ST_REM_MUL: cmd.rem_start = 1'b1;
            ST_REM_DIV: begin
                if (st.div_done) cmd.rem_done = 1'b1;
            end
            ST_BEGIN: cmd.begin_xfer = 1'b1;
            ST_OUT: cmd.out_valid = 1'b1;
            default: ;
        endcase
        if (state_reg == ST_DUR_MUL) cmd.dur_start = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

endmodule

FILE: sv/adf_dp.sv
module adf_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [adf_pkg::InW-1:0]  in_item,
    input  logic                     m_ready,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  adf_pkg::cmd_t            cmd,
    output adf_pkg::stat_t           st,
    output logic [adf_pkg::OutW-1:0] out_item
);
    import adf_pkg::*;

    logic [31:0] vclk_reg, cps_reg;
    logic        fix_reg;
    logic [31:0] addr_reg, len_reg, ctrl_reg, dac_reg, bits_reg;
    logic        busy_reg, full_reg, dirty_reg;
    logic [31:0] qa_reg [QueueDepth];
    logic [31:0] ql_reg [QueueDepth];
    logic [31:0] qd_reg [QueueDepth];
    logic [31:0] left_reg, latch_reg, rate_reg;

    logic [1:0]  op_reg;
    logic [2:0]  idx_reg;
    logic [31:0] wd_reg, wm_reg;
    logic [15:0] el_reg;

    logic [31:0] o_rd, o_addr, o_len, o_rate, o_bits;
    logic        o_start, o_fmt, o_irq, o_clr;

    logic [63:0] prod_reg;
    logic        div_start;
    logic [63:0] div_num, div_den, div_q;
    logic        div_done;
    logic [31:0] div4;
    logic [32:0] dac_p1;
    logic [31:0] masked, new_addr;
    logic        rate_div;  // divider holds the rate, else a 64-bit quotient

    assign dac_p1 = {1'b0, dac_reg} + 33'd1;
    assign div4 = {rate_reg[29:0], 2'b00};
    assign masked = (wd_reg & wm_reg);

    always_comb begin
        div_start = cmd.rate_start | cmd.dur_start | cmd.rem_start;
        div_num = {32'd0, vclk_reg};
        div_den = {31'd0, dac_p1};
        if (cmd.dur_start) begin
            div_num = prod_reg;
            div_den = {32'd0, div4};
        end else if (cmd.rem_start) begin
            div_num = prod_reg;
            div_den = {32'd0, qd_reg[0]};
        end
    end

    adf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .quo(div_q), .done(div_done)
    );

    assign new_addr = (addr_reg & ~wm_reg) | masked;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            {el_reg, wm_reg, wd_reg, idx_reg, op_reg} <= in_item;
            {o_rd, o_addr, o_len, o_rate, o_bits} <= '0;
            {o_start, o_fmt, o_irq, o_clr} <= '0;
        end
        if (cmd.rate_start) rate_div <= 1'b1;
        if (cmd.dur_start || cmd.rem_start) rate_div <= 1'b0;
        if (div_done && rate_div)
            rate_reg <= (dac_p1[32]) ? 32'd0 : div_q[31:0];
        if (cmd.mul_dur) prod_reg <= 64'(len_reg) * 64'(cps_reg);
        if (cmd.rem_mul) prod_reg <= 64'(left_reg) * 64'(ql_reg[0]);
        if (cmd.rem_done) o_rd <= div_q[31:0] & ~32'd7;

        if (cmd.exec) begin
            case (op_reg)
                OP_READ: begin
                    case (idx_reg)
                        R_ADDR: o_rd <= addr_reg;
                        R_CTRL: o_rd <= ctrl_reg;
                        R_STAT: o_rd <= {full_reg, busy_reg, 30'd0};
                        R_DAC:  o_rd <= dac_reg;
                        R_BITS: o_rd <= bits_reg;
                        default: o_rd <= '0;
                    endcase
                end
                OP_WRITE: begin
                    case (idx_reg)
                        R_ADDR: begin
                            if (fix_reg) begin
                                if (latch_reg == 32'd0) begin
                                    latch_reg <= new_addr;
                                    addr_reg <= new_addr;
                                end else begin
                                    addr_reg <= latch_reg;
                                end
                            end else begin
                                addr_reg <= new_addr;
                            end
                        end
                        R_CTRL: ctrl_reg <= (ctrl_reg & ~wm_reg) | masked;
                        R_STAT: o_clr <= 1'b1;
                        R_DAC: begin
                            if (dac_reg != masked) dirty_reg <= 1'b1;
                            dac_reg <= (dac_reg & ~wm_reg) | masked;
                        end
                        R_BITS: begin
                            if (bits_reg != masked) dirty_reg <= 1'b1;
                            bits_reg <= (bits_reg & ~wm_reg) | masked;
                        end
                        default: ;
                    endcase
                end
                OP_TIME: begin
                    if (busy_reg) begin
                        if ({16'd0, el_reg} >= left_reg) begin
                            left_reg <= '0;
                            o_irq <= 1'b1;
                            if (full_reg) begin
                                qa_reg[0] <= qa_reg[1];
                                ql_reg[0] <= ql_reg[1];
                                qd_reg[0] <= qd_reg[1];
                                full_reg <= 1'b0;
                            end else begin
                                busy_reg <= 1'b0;
                            end
                        end else begin
                            left_reg <= left_reg - {16'd0, el_reg};
                        end
                    end
                end
                default: ;
            endcase
        end

        if (cmd.rate_start && op_reg == OP_WRITE)
            len_reg <= (len_reg & ~wm_reg) | masked;

        if (cmd.len_queue) begin
            if (busy_reg) begin
                qa_reg[1] <= addr_reg;
                ql_reg[1] <= len_reg;
                qd_reg[1] <= (div4 == 32'd0) ? 32'd0 : div_q[31:0];
                full_reg <= 1'b1;
            end else begin
                qa_reg[0] <= addr_reg;
                ql_reg[0] <= len_reg;
                qd_reg[0] <= (div4 == 32'd0) ? 32'd0 : div_q[31:0];
                busy_reg <= 1'b1;
            end
        end

        if (cmd.begin_xfer) begin
            o_start <= 1'b1;
            o_addr <= qa_reg[0];
            o_len <= ql_reg[0];
            left_reg <= qd_reg[0];
            if (dirty_reg) begin
                o_fmt <= 1'b1;
                o_rate <= (dac_reg == 32'd0) ? RATE_DEFAULT : rate_reg;
                o_bits <= (bits_reg == 32'd0) ? BITS_DEFAULT : bits_reg + 32'd1;
                dirty_reg <= 1'b0;
            end
        end

        if (cfg_we) begin
            case (cfg_index)
                CFG_VCLK: vclk_reg <= cfg_data;
                CFG_CPS:  cps_reg <= cfg_data;
                CFG_FIX:  fix_reg <= cfg_data[0];
                default: ;
            endcase
        end

        if (!aresetn) begin
            vclk_reg <= VCLK_RESET;
            cps_reg <= CPS_RESET;
            fix_reg <= 1'b0;
            addr_reg <= '0;
            len_reg <= '0;
            ctrl_reg <= '0;
            dac_reg <= '0;
            bits_reg <= '0;
            busy_reg <= 1'b0;
            full_reg <= 1'b0;
            dirty_reg <= 1'b0;
            left_reg <= '0;
            latch_reg <= '0;
            rate_div <= 1'b0;
            for (int i = 0; i < QueueDepth; i++) begin
                qa_reg[i] <= '0;
                ql_reg[i] <= '0;
                qd_reg[i] <= '0;
            end
        end
    end

    always_comb begin
        st.op = op_reg;
        st.idx = idx_reg;
        st.busy = busy_reg;
        st.full = full_reg;
        st.time_end = busy_reg && ({16'd0, el_reg} >= left_reg);
        st.rem_ok = busy_reg && (qd_reg[0] != 32'd0) && (left_reg != 32'd0);
        st.dirty = dirty_reg;
        st.div_done = div_done;
        st.out_taken = m_ready;
    end

    assign out_item = {o_clr, o_irq, o_bits, o_rate, o_fmt, o_len, o_addr, o_start, o_rd};

endmodule

FILE: verif/audio_dma_fifo_controller_tb.sv
`timescale 1ns / 100ps

module audio_dma_fifo_controller_tb;
    import adf_pkg::*;

    localparam logic [1:0]  OP_NONE   = 2'd3;
    localparam logic [31:0] STAT_BUSY = 32'h4000_0000;
    localparam logic [31:0] STAT_FULL = 32'h8000_0000;
    localparam int          SETTLE    = 200;
    localparam int          LIMIT     = 3_000_000;
    localparam int          PER_PHASE = 300;

    typedef struct packed {
        logic        irq_clear;
        logic        irq_raise;
        logic [31:0] sample_bits;
        logic [31:0] sample_rate;
        logic        format_update;
        logic [31:0] xfer_len;
        logic [31:0] dma_address;
        logic        dma_start;
        logic [31:0] read_data;
    } dma_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  idx;
        logic [31:0] data;
        logic [31:0] mask;
        logic [15:0] elapsed;
        bit          typed;
        dma_result_t want;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    audio_dma_fifo_controller dut (.*);

    // shadow of the block
    logic [31:0] regs [RegCount];
    logic [31:0] q_addr [QueueDepth];
    logic [31:0] q_len [QueueDepth];
    logic [31:0] q_dur [QueueDepth];
    logic [31:0] counts_left, latch_pos, vclk_hz, cps_hz;
    logic        fmt_dirty, fix_pos;

    dma_result_t expected_words[$];
    dir_row_t    dir_rows[$];
    int send_idle_pct = 0, recv_stall_pct = 0;
    int errors = 0, words_seen = 0, starts_seen = 0, irqs_seen = 0, items_sent = 0;
    int cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] dac_rate();
        logic [31:0] div;
        div = regs[R_DAC] + 32'd1;
        return (div == 0) ? 32'd0 : vclk_hz / div;
    endfunction

    function automatic logic [31:0] xfer_duration();
        logic [31:0] div;
        logic [63:0] num;
        div = 32'd4 * dac_rate();
        if (div == 0) return 32'd0;
        num = {32'd0, regs[R_LEN]} * {32'd0, cps_hz};
        return 32'(num / {32'd0, div});
    endfunction

    function automatic void start_entry0(ref dma_result_t r);
        r.dma_start   = 1'b1;
        r.dma_address = q_addr[0];
        r.xfer_len    = q_len[0];
        if (fmt_dirty) begin
            r.format_update = 1'b1;
            r.sample_rate   = (regs[R_DAC] == 0) ? RATE_DEFAULT : dac_rate();
            r.sample_bits   = (regs[R_BITS] == 0) ? BITS_DEFAULT : regs[R_BITS] + 32'd1;
            fmt_dirty = 1'b0;
        end
        counts_left = q_dur[0];
    endfunction

    function automatic void reg_update(int i, logic [31:0] d, logic [31:0] m);
        regs[i] = (regs[i] & ~m) | (d & m);
    endfunction

    function automatic dma_result_t predict_word(logic [1:0] op, logic [2:0] idx,
            logic [31:0] d, logic [31:0] m, logic [15:0] el);
        dma_result_t r;
        logic [63:0] prod;
        logic [31:0] dur;
        int b;
        r = '0;
        b = (regs[R_STAT] & STAT_BUSY) != 0;
        case (op)
            OP_READ: begin
                if (idx == R_LEN) begin
                    if (b && q_dur[0] != 0 && counts_left != 0) begin
                        prod = {32'd0, counts_left} * {32'd0, q_len[0]};
                        r.read_data = 32'(prod / {32'd0, q_dur[0]}) & ~32'd7;
                    end
                end else if (idx < RegCount) begin
                    r.read_data = regs[idx];
                end
            end
            OP_WRITE: begin
                if (idx == R_ADDR) begin
                    reg_update(R_ADDR, d, m);
                    if (fix_pos) begin
                        if (latch_pos == 0) latch_pos = regs[R_ADDR];
                        regs[R_ADDR] = latch_pos;
                    end
                end else if (idx == R_LEN) begin
                    reg_update(R_LEN, d, m);
                    dur = xfer_duration();
                    if (b) begin
                        q_addr[1] = regs[R_ADDR];
                        q_len[1]  = regs[R_LEN];
                        q_dur[1]  = dur;
                        regs[R_STAT] |= STAT_FULL;
                    end else begin
                        q_addr[0] = regs[R_ADDR];
                        q_len[0]  = regs[R_LEN];
                        q_dur[0]  = dur;
                        regs[R_STAT] |= STAT_BUSY;
                        start_entry0(r);
                    end
                end else if (idx == R_STAT) begin
                    r.irq_clear = 1'b1;
                end else if (idx == R_DAC || idx == R_BITS) begin
                    if (regs[idx] != (d & m)) fmt_dirty = 1'b1;
                    reg_update(idx, d, m);
                end else if (idx < RegCount) begin
                    reg_update(idx, d, m);
                end
            end
            OP_TIME: begin
                if (b) begin
                    if ({16'd0, el} >= counts_left) begin
                        counts_left = '0;
                        if (regs[R_STAT] & STAT_FULL) begin
                            q_addr[0] = q_addr[1];
                            q_len[0]  = q_len[1];
                            q_dur[0]  = q_dur[1];
                            regs[R_STAT] &= ~STAT_FULL;
                            start_entry0(r);
                        end else begin
                            regs[R_STAT] &= ~STAT_BUSY;
                        end
                        r.irq_raise = 1'b1;
                    end else begin
                        counts_left -= {16'd0, el};
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(logic [1:0] op, logic [2:0] idx, logic [31:0] d,
            logic [31:0] m, logic [15:0] el, bit typed = 0, dma_result_t want = '0);
        dma_result_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, el, m, d, idx, op};
        // tready only moves at rising edges, so the falling edge shows the next edge's value
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        p = predict_word(op, idx, d, m, el);
        expected_words.push_back(typed ? want : p);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] i, logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= i;
        cfg_data  <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (i)
            CFG_VCLK: vclk_hz = v;
            CFG_CPS:  cps_hz = v;
            CFG_FIX:  fix_pos = v[0];
            default: ;
        endcase
    endtask

    task automatic add_row(logic [1:0] op, logic [2:0] idx, logic [31:0] d, logic [31:0] m,
            logic [15:0] el, bit typed = 0, logic [31:0] rd = 0, logic irqc = 0);
        dir_row_t row;
        row.op = op; row.idx = idx; row.data = d; row.mask = m; row.elapsed = el;
        row.typed = typed;
        row.want = '0;
        row.want.read_data = rd;
        row.want.irq_clear = irqc;
        dir_rows.push_back(row);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("word %0d %s: expected %h got %h", words_seen, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        dma_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[163:0];
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_words.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("dma_start", {31'd0, want.dma_start}, {31'd0, got.dma_start});
                check_field("dma_address", want.dma_address, got.dma_address);
                check_field("xfer_len", want.xfer_len, got.xfer_len);
                check_field("format_update", {31'd0, want.format_update},
                            {31'd0, got.format_update});
                check_field("sample_rate", want.sample_rate, got.sample_rate);
                check_field("sample_bits", want.sample_bits, got.sample_bits);
                check_field("irq_raise", {31'd0, want.irq_raise}, {31'd0, got.irq_raise});
                check_field("irq_clear", {31'd0, want.irq_clear}, {31'd0, got.irq_clear});
            end
            words_seen++;
            starts_seen += int'(got.dma_start);
            irqs_seen += int'(got.irq_raise);
        end
    end

    // mostly well-formed dma traffic, some noise
    task automatic random_word(output bit counted);
        int k;
        logic [31:0] d, m;
        k = $urandom_range(99);
        m = ($urandom_range(3) == 0) ? $urandom : 32'hFFFF_FFFF;
        counted = 1;
        if (k < 25) begin
            d = ($urandom_range(7) == 0) ? $urandom : $urandom_range(4095);
            send_word(OP_WRITE, R_LEN, d, m, 16'($urandom));
        end else if (k < 45) begin
            send_word(OP_TIME, 3'($urandom), $urandom, $urandom,
                      ($urandom_range(4) == 0) ? 16'($urandom_range(1, 65535))
                                               : 16'($urandom_range(1, 3000)));
        end else if (k < 55) begin
            send_word(OP_WRITE, R_ADDR, $urandom, m, 16'($urandom));
        end else if (k < 65) begin
            d = ($urandom_range(9) == 0) ? $urandom : $urandom_range(7);
            send_word(OP_WRITE, $urandom_range(1) ? R_DAC : R_BITS, d, m, 16'($urandom));
        end else if (k < 80) begin
            send_word(OP_READ, 3'($urandom_range(7)), $urandom, $urandom, 16'($urandom));
        end else if (k < 85) begin
            send_word(OP_WRITE, R_STAT, $urandom, $urandom, 16'($urandom));
        end else if (k < 90) begin
            send_word(OP_WRITE, R_CTRL, $urandom, $urandom, 16'($urandom));
        end else if (k < 95) begin
            counted = 0;
            if ($urandom_range(1))
                send_word(OP_NONE, 3'($urandom), $urandom, $urandom, 16'($urandom));
            else
                send_word(OP_WRITE, 3'($urandom_range(6, 7)), $urandom, $urandom,
                          16'($urandom));
        end else begin
            send_word(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom, $urandom,
                      16'($urandom));
        end
    endtask

    initial begin
        int n;
        bit counted;
        logic [31:0] vclk_set [6];
        logic [31:0] cps_set [6];
        int idle_set [4];
        int stall_set [4];
        vclk_set = '{VCLK_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1_000_000, VCLK_RESET, 32'd8000};
        cps_set  = '{CPS_RESET, CPS_RESET, 32'hFFFF_FFFF, 32'd0, 32'd1_000, 32'd70_000};
        idle_set  = '{0, 47, 0, 36};
        stall_set = '{0, 0, 47, 36};
        foreach (regs[i]) regs[i] = '0;
        foreach (q_addr[i]) begin
            q_addr[i] = '0; q_len[i] = '0; q_dur[i] = '0;
        end
        counts_left = '0; latch_pos = '0; fmt_dirty = 1'b0;
        vclk_hz = VCLK_RESET; cps_hz = CPS_RESET; fix_pos = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(OP_READ,  R_STAT, '0, '0, 16'd1, 1, 32'd0);
        add_row(OP_READ,  R_LEN,  '0, '0, 16'd1, 1, 32'd0);
        add_row(OP_WRITE, R_STAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 1, 32'd0, 1'b1);
        add_row(OP_WRITE, R_ADDR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_row(OP_WRITE, R_DAC,  32'd0, 32'hFFFF_FFFF, 16'd1);
        add_row(OP_WRITE, R_LEN,  32'd1000, 32'hFFFF_FFFF, 16'd1);
        add_row(OP_READ,  R_LEN,  '0, '0, 16'd1);
        add_row(OP_WRITE, R_LEN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        // second length write while full replaces the waiting entry
        add_row(OP_WRITE, R_LEN,  32'd8, 32'hFFFF_FFFF, 16'd1);
        add_row(OP_READ,  R_STAT, '0, '0, 16'd1);
        add_row(OP_TIME,  R_ADDR, '0, '0, 16'hFFFF);
        add_row(OP_WRITE, R_BITS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        // dac + 1 wraps: zero sample rate, zero duration
        add_row(OP_WRITE, R_DAC,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        add_row(OP_TIME,  R_ADDR, '0, '0, 16'hFFFF);
        add_row(OP_WRITE, R_LEN,  32'h10, 32'hFFFF_FFFF, 16'd1);
        add_row(OP_TIME,  R_ADDR, '0, '0, 16'd1);
        add_row(OP_WRITE, R_DAC,  32'hFFFF_FFFF, 32'h3, 16'd1);
        add_row(OP_WRITE, R_BITS, 32'd0, 32'hFFFF_FFFF, 16'd1);
        add_row(OP_READ,  R_DAC,  '0, '0, 16'd1);
        add_row(OP_WRITE, 3'd6,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        add_row(OP_READ,  3'd7,   '0, '0, 16'd1, 1, 32'd0);
        add_row(OP_NONE,  R_LEN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 32'd0);
        add_row(OP_WRITE, R_CTRL, 32'hA5A5_A5A5, 32'hFFFF_0000, 16'd1);
        add_row(OP_WRITE, R_LEN,  32'd0, 32'hFFFF_FFFF, 16'd1);
        add_row(OP_TIME,  R_ADDR, '0, '0, 16'd1);
        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].data, dir_rows[i].mask,
                      dir_rows[i].elapsed, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            // block must be idle before the config port is touched
            drain();
            write_cfg(CFG_VCLK, vclk_set[ph]);
            write_cfg(CFG_CPS, cps_set[ph]);
            write_cfg(CFG_FIX, {31'd0, (ph == 3 || ph == 4)});
            send_idle_pct  = idle_set[ph % 4];
            recv_stall_pct = stall_set[ph % 4];
            n = 0;
            while (n < PER_PHASE) begin
                random_word(counted);
                n += counted;
            end
        end
        drain();

        $display("sent %0d words, checked %0d results: %0d transfer starts, %0d interrupts",
                 items_sent, words_seen, starts_seen, irqs_seen);
        $display("six clock settings incl. zero and all-ones, fixed position on and off");
        if (errors == 0 && expected_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/adf_pkg.sv
sv/adf_div.sv
sv/adf_ctrl.sv
sv/adf_dp.sv
sv/audio_dma_fifo_controller.sv
verif/audio_dma_fifo_controller_tb.sv
